FILE: hdl/linear_congruence_solver_top_assert.svh
// Assertion macros shared by the solver's modules.
// They expect signals named clock and reset in the scope where they are used.
`ifndef LINEAR_CONGRUENCE_SOLVER_TOP_ASSERT_SVH
`define LINEAR_CONGRUENCE_SOLVER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define LCS_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lcs assertion failed");

// Consequent checked in the cycle after the antecedent
`define LCS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lcs assertion failed");

`endif

FILE: hdl/lcs_pkg.sv
package lcs_pkg;

   // Operand width of a, b and m
   localparam int VALUE_WIDTH = 31;
   // Fixed width of the solution field
   localparam int SOL_W = 31;
   // Coefficients are signed, one sign bit and one guard bit over the operands
   localparam int COEF_W = VALUE_WIDTH + 2;
   localparam int STEP_BOUND = 2 * VALUE_WIDTH + 4;
   localparam int STEP_W = $clog2(STEP_BOUND + 1);
   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic signed [COEF_W-1:0] coef_type;

   // Commands from the controller to the datapath
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,      // capture a transaction's operands
      OP_EUC_DIV,   // start r0 / r1
      OP_EUC_UPD,   // shift the remainder and coefficient sequences
      OP_GCD_DIV,   // start b / d
      OP_SRED_DIV,  // keep b/d, start |s0| / m
      OP_XR_KDIV,   // fix xr from the remainder, start (b/d) / m
      OP_MUL_INIT,  // k from the remainder, clear the accumulator
      OP_MUL_STEP,  // one bit of the modular product
      OP_FAIL,      // no solution
      OP_PUBLISH    // copy the result into the response register
   } dp_op_type;

   typedef struct packed {
      logic m_zero;
      logic r1_zero;
      logic steps_max;
      logic div_done;
      logic div_rem_zero;
      logic mul_last;
   } dp_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EUC_TEST,
      ST_EUC_WAIT,
      ST_EUC_UPD,
      ST_GCD_WAIT,
      ST_S_WAIT,
      ST_K_WAIT,
      ST_MUL,
      ST_FINISH
   } ctrl_state_type;

endpackage

FILE: hdl/lcs_if.sv
// Request channel: one congruence a*x = b (mod m)
interface lcs_req_if;
   logic                      valid;
   logic                      ready;
   logic [lcs_pkg::VALUE_WIDTH-1:0] coeff_a;
   logic [lcs_pkg::VALUE_WIDTH-1:0] rhs_b;
   logic [lcs_pkg::VALUE_WIDTH-1:0] modulus;

   modport source (output valid, coeff_a, rhs_b, modulus, input ready);
   modport sink   (input valid, coeff_a, rhs_b, modulus, output ready);
endinterface

// Response channel: solvable flag and solution
interface lcs_rsp_if;
   logic                  valid;
   logic                  ready;
   logic                  solvable;
   logic [lcs_pkg::SOL_W-1:0] solution;

   modport source (output valid, solvable, solution, input ready);
   modport sink   (input valid, solvable, solution, output ready);
endinterface

FILE: hdl/linear_congruence_solver_top.sv
// Channel  | Direction | Payload
// req_chan | in        | coeff_a, rhs_b, modulus
// rsp_chan | out       | solvable, solution
//
// One transaction at a time; each Euclid step runs a division through the shared
// one-bit-per-cycle divider, then three more divisions and a serial modular product.
// Synchronous active-high reset returns the sequencer to idle with no response pending.
// A waiting response does not block acceptance; only publishing the next one waits.
module linear_congruence_solver_top (
   input  logic      clock,
   input  logic      reset,
   lcs_req_if.sink   req_chan,
   lcs_rsp_if.source rsp_chan
);

   lcs_pkg::dp_op_type     op;
   lcs_pkg::dp_status_type status;

   lcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .op        (op)
   );

   lcs_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .op           (op),
      .in_a         (req_chan.coeff_a),
      .in_b         (req_chan.rhs_b),
      .in_m         (req_chan.modulus),
      .status       (status),
      .rsp_solvable (rsp_chan.solvable),
      .rsp_solution (rsp_chan.solution)
   );

endmodule

FILE: hdl/lcs_div.sv
// Restoring divider, one quotient bit per cycle
module lcs_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  lcs_pkg::value_type   dividend,
   input  lcs_pkg::value_type   divisor,
   output logic                 done,
   output lcs_pkg::value_type   quot,
   output lcs_pkg::value_type   rem
);

   localparam int W = lcs_pkg::VALUE_WIDTH;

   logic [W-1:0] quot_ff, quot_in;
   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] dvsr_ff, dvsr_in;
   logic [lcs_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [W:0] shifted;
   logic [W:0] trial;

   // Trial subtraction of the divisor from the shifted partial remainder
   always_comb begin
      shifted = {rem_ff, quot_ff[W-1]};
      trial   = shifted - {1'b0, dvsr_ff};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dvsr_in = divisor;
         cnt_in  = lcs_pkg::CNT_W'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[W]) begin
            rem_in = shifted[W-1:0];
         end else begin
            rem_in = trial[W-1:0];
         end
         quot_in = {quot_ff[W-2:0], ~trial[W]};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == lcs_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

FILE: hdl/lcs_datapath.sv
// Operand registers, Euclid sequences, normalisation and serial modular product
module lcs_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  lcs_pkg::dp_op_type         op,
   input  lcs_pkg::value_type         in_a,
   input  lcs_pkg::value_type         in_b,
   input  lcs_pkg::value_type         in_m,
   output lcs_pkg::dp_status_type     status,
   output logic                       rsp_solvable,
   output logic [lcs_pkg::SOL_W-1:0]  rsp_solution
);

   localparam int W = lcs_pkg::VALUE_WIDTH;
   localparam int CW = lcs_pkg::COEF_W;

   lcs_pkg::value_type r0_ff, r0_in, r1_ff, r1_in;
   lcs_pkg::coef_type  s0_ff, s0_in, s1_ff, s1_in;
   lcs_pkg::value_type b_ff, b_in, m_ff, m_in;
   lcs_pkg::value_type xr_ff, xr_in, k_ff, k_in;
   lcs_pkg::value_type acc_ff, acc_in, add_ff, add_in;
   logic [lcs_pkg::STEP_W-1:0] steps_ff, steps_in;
   logic [lcs_pkg::CNT_W-1:0] bit_ff, bit_in;
   logic solv_ff, solv_in;
   logic rsp_solv_ff, rsp_solv_in;
   logic [lcs_pkg::SOL_W-1:0] rsp_sol_ff, rsp_sol_in;

   logic div_start;
   lcs_pkg::value_type div_dividend, div_divisor, div_quot, div_rem;
   logic div_done;

   lcs_pkg::coef_type prod;
   lcs_pkg::coef_type s0_mag;
   logic [W:0] acc_sum, acc_red, add_dbl, add_red;

   lcs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // Divider operand selection
   always_comb begin
      s0_mag       = s0_ff[CW-1] ? -s0_ff : s0_ff;
      div_start    = 1'b0;
      div_dividend = r0_ff;
      div_divisor  = r1_ff;
      unique case (op)
         lcs_pkg::OP_EUC_DIV: begin
            div_start = 1'b1;
         end
         lcs_pkg::OP_GCD_DIV: begin
            div_start    = 1'b1;
            div_dividend = b_ff;
            div_divisor  = r0_ff;
         end
         lcs_pkg::OP_SRED_DIV: begin
            div_start    = 1'b1;
            div_dividend = s0_mag[W-1:0];
            div_divisor  = m_ff;
         end
         lcs_pkg::OP_XR_KDIV: begin
            div_start    = 1'b1;
            div_dividend = b_ff;
            div_divisor  = m_ff;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   // Coefficient product and modular product step
   always_comb begin
      prod    = CW'(signed'({2'b00, div_quot}) * s1_ff);
      acc_sum = {1'b0, acc_ff} + (k_ff[0] ? {1'b0, add_ff} : '0);
      acc_red = (acc_sum >= {1'b0, m_ff}) ? acc_sum - {1'b0, m_ff} : acc_sum;
      add_dbl = {add_ff, 1'b0};
      add_red = (add_dbl >= {1'b0, m_ff}) ? add_dbl - {1'b0, m_ff} : add_dbl;
   end

   // Register updates per command
   always_comb begin
      r0_in = r0_ff;   r1_in = r1_ff;
      s0_in = s0_ff;   s1_in = s1_ff;
      b_in = b_ff;     m_in = m_ff;
      xr_in = xr_ff;   k_in = k_ff;
      acc_in = acc_ff; add_in = add_ff;
      steps_in = steps_ff;
      bit_in = bit_ff;
      solv_in = solv_ff;
      rsp_solv_in = rsp_solv_ff;
      rsp_sol_in = rsp_sol_ff;
      unique case (op)
         lcs_pkg::OP_LOAD: begin
            r0_in = in_a;
            r1_in = in_m;
            m_in  = in_m;
            b_in  = in_b;
            s0_in = CW'(1);
            s1_in = '0;
            steps_in = '0;
         end
         lcs_pkg::OP_EUC_UPD: begin
            r0_in = r1_ff;
            r1_in = div_rem;
            s0_in = s1_ff;
            s1_in = s0_ff - prod;
            steps_in = steps_ff + 1'b1;
         end
         lcs_pkg::OP_SRED_DIV: begin
            b_in = div_quot;
         end
         lcs_pkg::OP_XR_KDIV: begin
            if (s0_ff[CW-1] && div_rem != '0) begin
               xr_in = m_ff - div_rem;
            end else if (s0_ff[CW-1]) begin
               xr_in = '0;
            end else begin
               xr_in = div_rem;
            end
         end
         lcs_pkg::OP_MUL_INIT: begin
            k_in    = div_rem;
            acc_in  = '0;
            add_in  = xr_ff;
            bit_in  = '0;
            solv_in = 1'b1;
         end
         lcs_pkg::OP_MUL_STEP: begin
            acc_in = acc_red[W-1:0];
            add_in = add_red[W-1:0];
            k_in   = k_ff >> 1;
            bit_in = bit_ff + 1'b1;
         end
         lcs_pkg::OP_FAIL: begin
            acc_in  = '0;
            solv_in = 1'b0;
         end
         lcs_pkg::OP_PUBLISH: begin
            rsp_solv_in = solv_ff;
            rsp_sol_in  = lcs_pkg::SOL_W'(acc_ff);
         end
         default: begin
            steps_in = steps_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      r0_ff <= r0_in;   r1_ff <= r1_in;
      s0_ff <= s0_in;   s1_ff <= s1_in;
      b_ff <= b_in;     m_ff <= m_in;
      xr_ff <= xr_in;   k_ff <= k_in;
      acc_ff <= acc_in; add_ff <= add_in;
      steps_ff <= steps_in;
      bit_ff <= bit_in;
      solv_ff <= solv_in;
      rsp_solv_ff <= rsp_solv_in;
      rsp_sol_ff <= rsp_sol_in;
   end

   // Status back to the controller
   assign status.m_zero       = (m_ff == '0);
   assign status.r1_zero      = (r1_ff == '0);
   assign status.steps_max    = (steps_ff == lcs_pkg::STEP_W'(lcs_pkg::STEP_BOUND));
   assign status.div_done     = div_done;
   assign status.div_rem_zero = (div_rem == '0);
   assign status.mul_last     = (bit_ff == lcs_pkg::CNT_W'(W - 1));

   assign rsp_solvable = rsp_solv_ff;
   assign rsp_solution = rsp_sol_ff;

endmodule

FILE: hdl/lcs_ctrl.sv
`include "linear_congruence_solver_top_assert.svh"

// Sequencer: steps the datapath through Euclid, normalisation and product
module lcs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  lcs_pkg::dp_status_type  status,
   output lcs_pkg::dp_op_type      op
);

   lcs_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic waiting_div;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      op           = lcs_pkg::OP_NONE;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         lcs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op       = lcs_pkg::OP_LOAD;
               state_in = lcs_pkg::ST_CHECK;
            end
         end
         lcs_pkg::ST_CHECK: begin
            if (status.m_zero) begin
               op       = lcs_pkg::OP_FAIL;
               state_in = lcs_pkg::ST_FINISH;
            end else begin
               state_in = lcs_pkg::ST_EUC_TEST;
            end
         end
         lcs_pkg::ST_EUC_TEST: begin
            if (status.r1_zero || status.steps_max) begin
               op       = lcs_pkg::OP_GCD_DIV;
               state_in = lcs_pkg::ST_GCD_WAIT;
            end else begin
               op       = lcs_pkg::OP_EUC_DIV;
               state_in = lcs_pkg::ST_EUC_WAIT;
            end
         end
         lcs_pkg::ST_EUC_WAIT: begin
            if (status.div_done) begin
               state_in = lcs_pkg::ST_EUC_UPD;
            end
         end
         lcs_pkg::ST_EUC_UPD: begin
            op       = lcs_pkg::OP_EUC_UPD;
            state_in = lcs_pkg::ST_EUC_TEST;
         end
         lcs_pkg::ST_GCD_WAIT: begin
            if (status.div_done && !status.div_rem_zero) begin
               op       = lcs_pkg::OP_FAIL;
               state_in = lcs_pkg::ST_FINISH;
            end else if (status.div_done) begin
               op       = lcs_pkg::OP_SRED_DIV;
               state_in = lcs_pkg::ST_S_WAIT;
            end
         end
         lcs_pkg::ST_S_WAIT: begin
            if (status.div_done) begin
               op       = lcs_pkg::OP_XR_KDIV;
               state_in = lcs_pkg::ST_K_WAIT;
            end
         end
         lcs_pkg::ST_K_WAIT: begin
            if (status.div_done) begin
               op       = lcs_pkg::OP_MUL_INIT;
               state_in = lcs_pkg::ST_MUL;
            end
         end
         lcs_pkg::ST_MUL: begin
            op = lcs_pkg::OP_MUL_STEP;
            if (status.mul_last) begin
               state_in = lcs_pkg::ST_FINISH;
            end
         end
         lcs_pkg::ST_FINISH: begin
            // wait for the response register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               op           = lcs_pkg::OP_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = lcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lcs_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   // States in which a divider result may arrive
   assign waiting_div = (state_ff == lcs_pkg::ST_EUC_WAIT) || (state_ff == lcs_pkg::ST_GCD_WAIT)
                     || (state_ff == lcs_pkg::ST_S_WAIT) || (state_ff == lcs_pkg::ST_K_WAIT);

   // A new response only ever comes out of the finishing state
   `LCS_ASSERT_SAME(a_rsp_from_finish, $rose(rsp_valid_ff), $past(state_ff == lcs_pkg::ST_FINISH))
   // An accepted transaction always goes to the modulus check
   `LCS_ASSERT_NEXT(a_accept_to_check, req_valid && req_ready, state_ff == lcs_pkg::ST_CHECK)
   // Divider completions only arrive while the sequencer waits on one
   `LCS_ASSERT_SAME(a_div_done_waiting, status.div_done, waiting_div)

endmodule

FILE: dv/lcs_tb_if.sv
`timescale 1ns / 1ps
package lcs_tb_pkg;

   // Request transaction
   typedef struct {
      lcs_pkg::value_type coeff_a;
      lcs_pkg::value_type rhs_b;
      lcs_pkg::value_type modulus;
   } congruence_type;

   // Response transaction
   typedef struct {
      logic                      solvable;
      logic [lcs_pkg::SOL_W-1:0] solution;
   } answer_type;
endpackage

FILE: dv/tb_linear_congruence_solver_top.sv
`timescale 1ns / 1ps
module tb_linear_congruence_solver_top;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int DRAIN_CYCLES = 3000;

   logic clock;
   logic reset;

   lcs_req_if req_chan ();
   lcs_rsp_if rsp_chan ();

   linear_congruence_solver_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   lcs_tb_pkg::congruence_type pending_q[$];
   lcs_tb_pkg::answer_type     answer_q[$];
   lcs_tb_pkg::congruence_type drv_item;
   int          mismatches = 0;
   int          cycle_count = 0;
   int          send_gap = 0;
   int          stall_count = 0;
   bit          stimulus_done = 0;
   bit          hold_sender = 0;

   // Exact modular product by shift-and-add
   function automatic logic [63:0] mul_mod(logic [63:0] p, logic [63:0] q, logic [63:0] m);
      logic [63:0] acc;
      logic [63:0] addend;
      acc = 0;
      addend = p;
      for (int i = 0; i < 64; i++) begin
         if (q[i]) acc = (acc + addend) % m;
         addend = (addend + addend) % m;
      end
      return acc;
   endfunction

   // Extended Euclid on (a, m), then x0*(b/d) reduced mod m
   function automatic lcs_tb_pkg::answer_type solve_congruence(lcs_tb_pkg::congruence_type c);
      lcs_tb_pkg::answer_type ans;
      logic [63:0] r0, r1, s0, s1, q, nr, ns, d, xr, k, mag, rem, m, b;
      ans.solvable = 1'b0;
      ans.solution = '0;
      m = 64'(c.modulus);
      b = 64'(c.rhs_b);
      if (m == 0) return ans;
      r0 = 64'(c.coeff_a);
      r1 = m;
      s0 = 1;
      s1 = 0;
      for (int st = 0; st < lcs_pkg::STEP_BOUND && r1 != 0; st++) begin
         q = r0 / r1;
         nr = r0 - q * r1;
         ns = s0 - q * s1;
         r0 = r1;
         r1 = nr;
         s0 = s1;
         s1 = ns;
      end
      d = r0;
      if (b % d != 0) return ans;
      if (s0[63]) begin
         mag = ~s0 + 1;
         rem = mag % m;
         xr = (rem != 0) ? m - rem : 0;
      end else begin
         xr = s0 % m;
      end
      k = (b / d) % m;
      ans.solvable = 1'b1;
      ans.solution = lcs_pkg::SOL_W'(mul_mod(xr, k, m));
      return ans;
   endfunction

   function automatic lcs_pkg::value_type rand_value();
      case ($urandom_range(0, 5))
         0: return lcs_pkg::value_type'($urandom_range(0, 16));
         1: return lcs_pkg::value_type'($urandom_range(0, 1000));
         2: return {lcs_pkg::VALUE_WIDTH{1'b1}} - lcs_pkg::value_type'($urandom_range(0, 3));
         default: return lcs_pkg::value_type'($urandom);
      endcase
   endfunction

   // Append one transaction to the pending queue
   task automatic add_item(lcs_pkg::value_type a, lcs_pkg::value_type b,
                           lcs_pkg::value_type m);
      lcs_tb_pkg::congruence_type c;
      c.coeff_a = a;
      c.rhs_b = b;
      c.modulus = m;
      pending_q = {pending_q, c};
   endtask

   // Clock
   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Stimulus
   initial begin
      lcs_pkg::value_type a, b, m, g;
      lcs_pkg::value_type all_ones;
      all_ones = {lcs_pkg::VALUE_WIDTH{1'b1}};
      reset = 1;
      repeat (6) @(posedge clock);
      reset <= 0;
      // directed corners
      add_item(1, 0, 1);
      add_item(all_ones, all_ones, all_ones);
      add_item(all_ones, all_ones, all_ones - 1'b1);
      add_item(0, 10, 5);       // zero coefficient, m divides b
      add_item(0, 11, 5);       // zero coefficient, unsolvable
      add_item(0, 0, 0);        // zero modulus
      add_item(7, 3, 0);        // zero modulus
      add_item(6, 4, 9);        // gcd 3 does not divide 4
      add_item(6, 3, 9);        // gcd 3 divides 3
      add_item(3, 2, 7);
      add_item(all_ones, 0, 2);
      add_item(1134903170, all_ones, 1836311903); // Fibonacci pair
      add_item(1836311903, 1, 1134903170);
      add_item(1 << 30, 1 << 29, all_ones);
      add_item(1 << 30, 1 << 20, 1 << 30);
      add_item(12, 5, 1);
      add_item(all_ones, all_ones, 1);
      // wait for everything to drain
      wait (pending_q.size() == 0 && answer_q.size() == 0);
      hold_sender = 1;
      repeat (5) @(posedge clock);
      hold_sender = 0;
      // random part, biased toward solvable cases via a shared factor
      for (int i = 0; i < 353; i++) begin
         a = rand_value();
         b = rand_value();
         m = rand_value();
         if ($urandom_range(0, 2) == 0) begin
            g = lcs_pkg::value_type'($urandom_range(1, 64));
            a = lcs_pkg::value_type'((a % 33554432) * g);
            m = lcs_pkg::value_type'((m % 33554432) * g);
            b = lcs_pkg::value_type'((b % 33554432) * g);
         end
         add_item(a, b, m);
         if (i == 180) begin
            wait (pending_q.size() == 0 && answer_q.size() == 0);
         end
      end
      wait (pending_q.size() == 0);
      stimulus_done = 1;
   end

   // Driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.coeff_a <= '0;
         req_chan.rhs_b <= '0;
         req_chan.modulus <= '0;
         send_gap <= 0;
      end else if (req_chan.valid && !req_chan.ready) begin
         // hold the transaction until accepted
      end else if (send_gap > 0) begin
         send_gap <= send_gap - 1;
         req_chan.valid <= 1'b0;
      end else if (pending_q.size() > 0 && !hold_sender) begin
         drv_item = pending_q.pop_front();
         answer_q = {answer_q, solve_congruence(drv_item)};
         req_chan.valid <= 1'b1;
         req_chan.coeff_a <= drv_item.coeff_a;
         req_chan.rhs_b <= drv_item.rhs_b;
         req_chan.modulus <= drv_item.modulus;
         send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   // Monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_count <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (answer_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: expected none got %0d/%0d",
                     rsp_chan.solvable, rsp_chan.solution);
            end else begin
               lcs_tb_pkg::answer_type exp_ans;
               exp_ans = answer_q.pop_front();
               if (rsp_chan.solvable !== exp_ans.solvable
                   || rsp_chan.solution !== exp_ans.solution) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("wrong answer: expected %0d/%0d got %0d/%0d",
                        exp_ans.solvable, exp_ans.solution,
                        rsp_chan.solvable, rsp_chan.solution);
               end
            end
            stall_count <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            rsp_chan.ready <= 1'b0;
         end else if (stall_count > 0) begin
            stall_count <= stall_count - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // End of run and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("linear_congruence_solver_top: mismatch");
         $finish;
      end
   end

   initial begin
      wait (stimulus_done && answer_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && answer_q.size() == 0) begin
         $display("linear_congruence_solver_top: match");
      end else begin
         $display("linear_congruence_solver_top: mismatch");
      end
      $finish;
   end

endmodule
